// ===== hw/rtl/ptvc_pkg.sv =====
`default_nettype none
package ptvc_pkg;
   localparam int DEPTH_DEF = 32;
   localparam int MAXV_DEF  = 4;
   localparam int VW        = 32;

   typedef enum logic [2:0] {
      FUNC_ADD   = 3'd0,
      FUNC_FLUSH = 3'd1,
      FUNC_CLEAR = 3'd2,
      FUNC_RSTAT = 3'd3,
      FUNC_QUERY = 3'd4
   } func_type;

   localparam logic [1:0] MD_BATCH = 2'd0;
   localparam logic [1:0] MD_FIFO  = 2'd1;
   localparam logic [1:0] MD_LRU   = 2'd2;
   localparam logic [1:0] MD_SPARE = 2'd3;   // behaves as FIFO

   localparam logic [1:0] CSR_MODE    = 2'd0;
   localparam logic [1:0] CSR_ENTRIES = 2'd1;
   localparam logic [1:0] CSR_LIMIT   = 2'd2;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic          clear;   // drop every entry
      logic          append;  // write key into the newest free position
      logic          lru_mv;  // move hit entry to the newest end
      logic          evict;   // shift the chain by one toward the oldest end
      logic [VW-1:0] key;
   } cell_cmd_type;
endpackage
`default_nettype wire

// ===== hw/rtl/ptvc_if.sv =====
`default_nettype none
interface ptvc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [31:0] vertex_0;
   logic [31:0] vertex_1;
   logic [31:0] vertex_2;
   logic [31:0] vertex_3;
   logic [2:0]  prim_vertices;
   logic [31:0] lead_vertex;
   logic        lead_valid;
   modport source (output valid, func, vertex_0, vertex_1, vertex_2, vertex_3,
                   prim_vertices, lead_vertex, lead_valid, input ready);
   modport sink (input valid, func, vertex_0, vertex_1, vertex_2, vertex_3,
                 prim_vertices, lead_vertex, lead_valid, output ready);
endinterface

interface ptvc_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  held_vertices;
   logic [31:0] primitives_seen;
   logic [31:0] transforms;
   logic [31:0] batches;
   logic [31:0] full_batches;
   logic        batch_started;
   logic signed [5:0] found_position;
   modport source (output valid, held_vertices, primitives_seen, transforms, batches,
                   full_batches, batch_started, found_position, input ready);
   modport sink (input valid, held_vertices, primitives_seen, transforms, batches,
                 full_batches, batch_started, found_position, output ready);
endinterface

interface ptvc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/post_transform_vertex_cache_model.sv =====
`default_nettype none
// Vertex cache model built as a chain of CACHE_DEPTH cells, oldest entry in
// cell 0. An add with n primitive vertices and s inserted vertices (n, plus one
// for a lead vertex outside batch mode) passes through these states from
// acceptance to a valid result: S_COUNT counts fresh vertices one per cycle,
// S_DECIDE decides the batch, S_INSERT inserts one vertex per cycle (each looked
// up against all cells), S_DONE applies the command and S_OUT loads the output
// register. Other commands pass through S_DONE and S_OUT only. The next
// transaction is accepted the cycle after the result is loaded, even while that
// result still waits, and no new request is taken before then; a finished
// command holds in S_OUT only while the previous result has not been taken.
module post_transform_vertex_cache_model
   import ptvc_pkg::*;
#(
   parameter int CACHE_DEPTH    = DEPTH_DEF,
   parameter int MAX_PRIM_VERTS = MAXV_DEF
) (
   input wire logic clock,
   input wire logic reset,
   ptvc_req_if.sink   req,
   ptvc_rsp_if.source rsp,
   ptvc_csr_if.sink   csr
);
   localparam int CW = $clog2(CACHE_DEPTH + 1);
   localparam int PW = $clog2(CACHE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_COUNT, S_DECIDE, S_INSERT, S_DONE, S_OUT
   } state_type;

   state_type     state_ff;
   logic [1:0]    mode_ff;
   logic [5:0]    entries_ff;
   logic [15:0]   limit_ff;
   logic [CW-1:0] count_ff;
   logic [16:0]   bprims_ff;
   logic [31:0]   st_prim_ff, st_xf_ff, st_bat_ff, st_full_ff;
   logic [2:0]    func_ff;
   logic [VW-1:0] vtx_ff [4];
   logic [2:0]    n_ff;
   logic [VW-1:0] lead_ff;
   logic          lead_ok_ff;
   logic [2:0]    idx_ff;      // vertex step, lead vertex first when present
   logic [2:0]    fresh_ff;
   logic          started_ff;
   logic [5:0]    found_ff;
   logic          rsp_valid_ff;
   logic [5:0]    out_held_ff;
   logic [31:0]   out_prim_ff, out_xf_ff, out_bat_ff, out_full_ff;
   logic          out_started_ff;
   logic [5:0]    out_found_ff;

   // effective entry count clamped to 1..CACHE_DEPTH
   logic [CW-1:0] eff;
   always_comb begin
      if (entries_ff == '0) eff = CW'(1);
      else if (32'(entries_ff) > CACHE_DEPTH) eff = CW'(CACHE_DEPTH);
      else eff = CW'(entries_ff);
   end

   // current key: lead (idx 0 when lead counts) then vertices
   logic          use_lead;
   logic [2:0]    vi;
   logic [VW-1:0] cur_key;
   logic          cur_skip;
   always_comb begin
      use_lead = lead_ok_ff && (mode_ff != MD_BATCH) && (state_ff == S_INSERT);
      vi       = use_lead ? idx_ff - 3'd1 : idx_ff;
      cur_key  = (use_lead && idx_ff == 3'd0) ? lead_ff : vtx_ff[vi[1:0]];
      cur_skip = use_lead && idx_ff != 3'd0 && vtx_ff[vi[1:0]] == lead_ff;
   end

   logic [2:0] steps;
   assign steps = n_ff + ((lead_ok_ff && mode_ff != MD_BATCH) ? 3'd1 : 3'd0);

   // cell chain
   cell_cmd_type          cmd;
   logic [VW-1:0]         keys [CACHE_DEPTH];
   logic [CACHE_DEPTH-1:0] valids, hits, mv_at;
   logic                  any_hit;
   logic [PW-1:0]         hit_pos;

   always_comb begin
      any_hit = |hits;
      hit_pos = '0;
      for (int k = CACHE_DEPTH - 1; k >= 0; k--) if (hits[k]) hit_pos = PW'(k);
      mv_at = '0;
      for (int k = 0; k < CACHE_DEPTH; k++) mv_at[k] = any_hit && (PW'(k) >= hit_pos);
   end

   logic ins_go, csr_acc, req_acc, out_load;
   assign req_acc  = req.valid && req.ready;
   assign csr_acc  = csr.valid && csr.ready;
   assign ins_go   = (state_ff == S_INSERT) && (idx_ff != steps) && !cur_skip;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      cmd        = '0;
      cmd.key    = cur_key;
      cmd.clear  = (csr_acc && csr.index == CSR_ENTRIES) ||
                   (state_ff == S_DONE && (func_ff == FUNC_FLUSH || func_ff == FUNC_CLEAR)) ||
                   (state_ff == S_DECIDE && started_ff);
      if (ins_go && !any_hit) begin
         if (count_ff < eff) cmd.append = 1'b1;
         else if (mode_ff != MD_BATCH) cmd.evict = 1'b1;
      end
      if (ins_go && any_hit && mode_ff == MD_LRU) cmd.lru_mv = 1'b1;
   end

   for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_cell
      logic [VW-1:0] nk;
      if (g == CACHE_DEPTH - 1) begin : g_end
         assign nk = cmd.key;
      end else begin : g_mid
         assign nk = keys[g+1];
      end
      ptvc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .is_tail  (CW'(g) == count_ff),
         .is_last  (CW'(g) + CW'(1) == count_ff),
         .mv_here  (mv_at[g]),
         .next_key (nk),
         .key_out  (keys[g]),
         .valid_out(valids[g]),
         .hit      (hits[g])
      );
   end

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;

   logic [CW:0] need;
   assign need = {1'b0, count_ff} + (CW+1)'(fresh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MD_BATCH;
         entries_ff   <= 6'd32;
         limit_ff     <= '0;
         count_ff     <= '0;
         bprims_ff    <= '0;
         st_prim_ff   <= '0;
         st_xf_ff     <= '0;
         st_bat_ff    <= '0;
         st_full_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff   <= 1'b1;
            out_held_ff    <= 6'(count_ff);
            out_prim_ff    <= st_prim_ff;
            out_xf_ff      <= st_xf_ff;
            out_bat_ff     <= st_bat_ff;
            out_full_ff    <= st_full_ff;
            out_started_ff <= started_ff && func_ff == FUNC_ADD && mode_ff == MD_BATCH;
            out_found_ff   <= found_ff;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_acc) begin
            unique case (csr.index)
               CSR_MODE: mode_ff <= csr.data[1:0];
               CSR_ENTRIES: begin
                  entries_ff <= csr.data[5:0];
                  count_ff   <= '0;
                  bprims_ff  <= '0;
               end
               CSR_LIMIT: limit_ff <= csr.data;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: if (req_acc) begin
               func_ff    <= req.func;
               vtx_ff[0]  <= req.vertex_0;
               vtx_ff[1]  <= req.vertex_1;
               vtx_ff[2]  <= req.vertex_2;
               vtx_ff[3]  <= req.vertex_3;
               n_ff       <= (32'(req.prim_vertices) > MAX_PRIM_VERTS) ?
                             3'(MAX_PRIM_VERTS) : req.prim_vertices;
               lead_ff    <= req.lead_vertex;
               lead_ok_ff <= req.lead_valid;
               idx_ff     <= '0;
               fresh_ff   <= '0;
               started_ff <= 1'b0;
               found_ff   <= '0;
               state_ff   <= (req.func == FUNC_ADD) ? S_COUNT : S_DONE;
            end
            S_COUNT: begin
               if (idx_ff == n_ff) begin
                  idx_ff   <= '0;
                  state_ff <= S_DECIDE;
                  st_prim_ff <= st_prim_ff + 32'd1;
                  if (mode_ff == MD_BATCH) begin
                     bprims_ff <= bprims_ff + 17'd1;
                     if (bprims_ff + 17'd1 > {1'b0, limit_ff})
                        st_full_ff <= st_full_ff + 32'd1;
                     started_ff <= (bprims_ff + 17'd1 > {1'b0, limit_ff}) ||
                                   (need > (CW+1)'(eff));
                  end else if (need > (CW+1)'(eff)) begin
                     st_xf_ff <= st_xf_ff + 32'(need - (CW+1)'(eff));
                  end
               end else begin
                  if (!any_hit) fresh_ff <= fresh_ff + 3'd1;
                  idx_ff <= idx_ff + 3'd1;
               end
            end
            S_DECIDE: begin
               if (started_ff) begin
                  st_bat_ff <= st_bat_ff + 32'd1;
                  st_xf_ff  <= st_xf_ff + 32'(count_ff);
                  count_ff  <= '0;
                  bprims_ff <= '0;
               end
               state_ff <= S_INSERT;
            end
            S_INSERT: begin
               if (idx_ff == steps) begin
                  state_ff <= S_DONE;
               end else begin
                  if (cmd.append) count_ff <= count_ff + CW'(1);
                  idx_ff <= idx_ff + 3'd1;
               end
            end
            S_DONE: begin
               unique case (func_ff)
                  FUNC_FLUSH: begin
                     st_xf_ff <= st_xf_ff + 32'(count_ff);
                     if (bprims_ff != '0) st_bat_ff <= st_bat_ff + 32'd1;
                     count_ff  <= '0;
                     bprims_ff <= '0;
                  end
                  FUNC_CLEAR: begin
                     count_ff  <= '0;
                     bprims_ff <= '0;
                  end
                  FUNC_RSTAT: begin
                     st_prim_ff <= '0;
                     st_xf_ff   <= '0;
                     st_bat_ff  <= '0;
                     st_full_ff <= '0;
                  end
                  FUNC_QUERY: found_ff <= any_hit ? 6'(hit_pos) : 6'h3f;
                  default: ;
               endcase
               state_ff <= S_OUT;
            end
            S_OUT: if (out_load) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // S_COUNT looks up vtx[idx]: reuse cur_key path (no lead in count phase)
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.held_vertices   = out_held_ff;
   assign rsp.primitives_seen = out_prim_ff;
   assign rsp.transforms      = out_xf_ff;
   assign rsp.batches         = out_bat_ff;
   assign rsp.full_batches    = out_full_ff;
   assign rsp.batch_started   = out_started_ff;
   assign rsp.found_position  = out_found_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(CACHE_DEPTH))
      else $error("held count above depth");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.append || cmd.evict) |-> !any_hit)
      else $error("insert on a hit");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff)
      else $error("result dropped before it was taken");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(hits) || cmd.clear)
      else $error("duplicate keys in cache");
   assert property (@(posedge clock) disable iff (reset)
      valids == ~({CACHE_DEPTH{1'b1}} << count_ff))
      else $error("valid cells disagree with held count");
endmodule
`default_nettype wire

// ===== hw/rtl/ptvc_cell.sv =====
`default_nettype none
// One cache position. Position 0 is the oldest entry; entries are kept packed
// toward position 0, so position k holds the k-th oldest vertex.
module ptvc_cell
   import ptvc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_cmd_type  cmd,
   input  wire logic          is_tail,      // this is the first free position
   input  wire logic          is_last,      // this is the newest valid position
   input  wire logic          mv_here,      // at or past the LRU hit position
   input  wire logic [VW-1:0] next_key,     // key of the neighbor toward newer end
   output logic [VW-1:0]      key_out,
   output logic               valid_out,
   output logic               hit
);
   logic [VW-1:0] key_ff, key_in;
   logic          valid_ff, valid_in;

   assign key_out   = key_ff;
   assign valid_out = valid_ff;
   assign hit       = valid_ff && (key_ff == cmd.key);

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.evict) begin
         // full ring: shift toward oldest, newest gets the key
         key_in = is_last ? cmd.key : next_key;
      end else if (cmd.lru_mv && mv_here) begin
         key_in = is_last ? cmd.key : next_key;
      end else if (cmd.append && is_tail) begin
         key_in   = cmd.key;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end
endmodule
`default_nettype wire
